// ===== rtl/core/msrb_pkg.sv =====
// shared types and constants for the run-length sprite blitter core
// no dependencies; imported by every module of the core
`default_nettype none

package msrb_pkg;

    localparam int unsigned PIXEL_BYTES = 2;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [15:0] END_MARK = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_BASE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_PITCH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y   = 2'd3;

    typedef enum logic [2:0] {
        PH_XOFF = 3'd0,
        PH_YOFF = 3'd1,
        PH_LEN  = 3'd2,
        PH_PIX  = 3'd3,
        PH_SKIP = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        CMD_ROW  = 2'd0,
        CMD_PIX  = 2'd1,
        CMD_SKIP = 2'd2,
        CMD_DONE = 2'd3
    } cmd_kind_t;

    // one queued command: for a row start word is the y offset, xoff the held x offset
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] word;
        logic [15:0] xoff;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/masked_sprite_rle_blitter_core.sv =====
// with the queue empty, an accepted pixel word is queued, then loaded into the m_ register
// throughput: one stream word per cycle unless the queue is full; a row start holds the writer
// in its row and busy states, absorbed by the queue since every row header spends three words
// reset: synchronous active-low aresetn clears parse phase, pointer, queue and config
// depends on msrb_pkg, msrb_front, msrb_queue, msrb_back
`default_nettype none

module masked_sprite_rle_blitter_core
    import msrb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,  // [15:0] stream_word
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [47:0]                m_tdata,  // [31:0] write_address, [47:32] pixel_value
    output logic [1:0]                 m_tuser   // [0] is_write, [1] image_done
);

    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    logic q_head_valid;
    cmd_t q_head_cmd;

    msrb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd)
    );

    msrb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    msrb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_head_valid),
        .q_cmd     (q_head_cmd),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/core/msrb_front.sv =====
// stream parser: accepts sprite words, tracks the parse phase and queues commands
// depends on msrb_pkg
`default_nettype none

module msrb_front
    import msrb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] stream_word
    input  wire logic        q_full,
    output logic             q_push,
    output cmd_t             q_cmd
);

    phase_t      phase_reg, phase_next;
    logic [15:0] held_x_reg, held_x_next;
    logic [14:0] words_left_reg, words_left_next;
    logic        accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_reg)
                PH_YOFF: phase_next = PH_LEN;
                PH_LEN:  phase_next = (s_tdata[15:1] != 15'd0) ? PH_PIX : PH_SKIP;
                PH_PIX:  phase_next = (words_left_reg == 15'd1) ? PH_SKIP : PH_PIX;
                PH_SKIP: phase_next = (s_tdata == END_MARK) ? PH_XOFF : PH_LEN;
                default: phase_next = (s_tdata == END_MARK) ? PH_XOFF : PH_YOFF;
            endcase
        end
    end

    // commands and counters
    always_comb begin
        q_push          = 1'b0;
        q_cmd.kind      = CMD_PIX;
        q_cmd.word      = s_tdata;
        q_cmd.xoff      = held_x_reg;
        held_x_next     = held_x_reg;
        words_left_next = words_left_reg;
        if (accept) begin
            case (phase_reg)
                PH_YOFF: begin
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_ROW;
                end
                PH_LEN: begin
                    // low bit of the byte length is dropped
                    words_left_next = s_tdata[15:1];
                end
                PH_PIX: begin
                    q_push          = 1'b1;
                    q_cmd.kind      = CMD_PIX;
                    words_left_next = words_left_reg - 15'd1;
                end
                PH_SKIP: begin
                    if (s_tdata != END_MARK) begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_SKIP;
                    end
                end
                default: begin
                    if (s_tdata == END_MARK) begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_DONE;
                    end else begin
                        held_x_next = s_tdata;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_XOFF;
            held_x_reg     <= 16'd0;
            words_left_reg <= 15'd0;
        end else begin
            phase_reg      <= phase_next;
            held_x_reg     <= held_x_next;
            words_left_reg <= words_left_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/msrb_queue.sv =====
// short command queue between parser and pixel writer
// depends on msrb_pkg
`default_nettype none

module msrb_queue
    import msrb_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("queue count not decremented on pop");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/msrb_back.sv =====
// pixel writer: holds config and write pointer, runs queued commands, drives result register
// depends on msrb_pkg
`default_nettype none

module msrb_back
    import msrb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  q_valid,
    input  cmd_t                       q_cmd,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [47:0]                m_tdata,  // [31:0] write_address, [47:32] pixel_value
    output logic [1:0]                 m_tuser   // [0] is_write, [1] image_done
);

    logic [31:0] frame_base_reg;
    logic [15:0] line_pitch_reg;
    logic [15:0] origin_x_reg;
    logic [15:0] origin_y_reg;

    logic [31:0] ptr_reg, ptr_next;
    logic        busy_reg, busy_next;
    logic [31:0] row_base_reg, row_base_next;
    logic [31:0] prod_reg, prod_next;

    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_addr_reg, m_addr_next;
    logic [15:0] m_pix_reg, m_pix_next;
    logic        m_wr_reg, m_wr_next;
    logic        m_done_reg, m_done_next;

    logic        out_free;
    logic        load;
    logic        row_start;
    logic [31:0] col_sum;
    logic [31:0] row_sum;
    logic [47:0] prod_full;

    assign out_free = !m_valid_reg || m_tready;

    // row start, on taking the row command: column term plus base, and the line product
    assign col_sum       = {{16{origin_x_reg[15]}}, origin_x_reg} + {16'd0, q_cmd.xoff};
    assign row_sum       = {{16{origin_y_reg[15]}}, origin_y_reg} + {16'd0, q_cmd.word};
    assign prod_full     = {16'd0, row_sum} * {32'd0, line_pitch_reg};
    assign prod_next     = prod_full[31:0];
    assign row_base_next = frame_base_reg + 32'(col_sum * 32'(PIXEL_BYTES));

    always_comb begin
        q_pop       = 1'b0;
        load        = 1'b0;
        row_start   = 1'b0;
        busy_next   = 1'b0;
        ptr_next    = ptr_reg;
        m_addr_next = m_addr_reg;
        m_pix_next  = m_pix_reg;
        m_wr_next   = m_wr_reg;
        m_done_next = m_done_reg;
        if (busy_reg) begin
            // row start, busy step
            ptr_next = row_base_reg + prod_reg;
        end else if (q_valid) begin
            case (q_cmd.kind)
                CMD_ROW: begin
                    q_pop     = 1'b1;
                    row_start = 1'b1;
                    busy_next = 1'b1;
                end
                CMD_PIX: begin
                    if (out_free) begin
                        q_pop       = 1'b1;
                        load        = 1'b1;
                        m_addr_next = ptr_reg;
                        m_pix_next  = q_cmd.word;
                        m_wr_next   = 1'b1;
                        m_done_next = 1'b0;
                        ptr_next    = ptr_reg + 32'(PIXEL_BYTES);
                    end
                end
                CMD_SKIP: begin
                    q_pop    = 1'b1;
                    ptr_next = ptr_reg + {16'd0, q_cmd.word};
                end
                CMD_DONE: begin
                    if (out_free) begin
                        q_pop       = 1'b1;
                        load        = 1'b1;
                        m_addr_next = 32'd0;
                        m_pix_next  = 16'd0;
                        m_wr_next   = 1'b0;
                        m_done_next = 1'b1;
                    end
                end
                default: begin
                    q_pop = 1'b1;
                end
            endcase
        end
        m_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg <= 32'd0;
            line_pitch_reg <= 16'd0;
            origin_x_reg   <= 16'd0;
            origin_y_reg   <= 16'd0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FRAME_BASE: frame_base_reg <= cfg_wdata;
                CFG_LINE_PITCH: line_pitch_reg <= cfg_wdata[15:0];
                CFG_ORIGIN_X:   origin_x_reg   <= cfg_wdata[15:0];
                CFG_ORIGIN_Y:   origin_y_reg   <= cfg_wdata[15:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= 32'd0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            ptr_reg     <= ptr_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (row_start) begin
            row_base_reg <= row_base_next;
            prod_reg     <= prod_next;
        end
        m_addr_reg <= m_addr_next;
        m_pix_reg  <= m_pix_next;
        m_wr_reg   <= m_wr_next;
        m_done_reg <= m_done_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pix_reg, m_addr_reg};
    assign m_tuser  = {m_done_reg, m_wr_reg};

`ifndef ASSERT_OFF
    a_busy_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |=> !busy_reg)
        else $error("row start held longer than two cycles");
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !q_pop)
        else $error("command taken during row start");
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_wr_reg != m_done_reg))
        else $error("result is neither or both of write and done");
    a_pix_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && m_wr_next) |=> ptr_reg == $past(ptr_reg) + 32'(PIXEL_BYTES))
        else $error("pointer not advanced after pixel write");
`endif

endmodule

`default_nettype wire
